// ===== design/cct_pkg.sv =====
// Package for the character class tokenizer: transfer payload types, token kind
// and scan mode codes, character constants and class functions.
// No dependencies.
package cct_pkg;

    localparam int MAX_TEXT_DEFAULT = 65536;
    localparam int RES_DEPTH        = 4;

    typedef enum logic [2:0] {
        KIND_NEWLINE = 3'd0,
        KIND_SPACE   = 3'd1,
        KIND_IDENT   = 3'd2,
        KIND_NUMBER  = 3'd3,
        KIND_STRING  = 3'd4,
        KIND_UNTERM  = 3'd5,
        KIND_INVALID = 3'd6
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_CR,
        MODE_MINUS,
        MODE_SPACE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_text;
    } cct_item_t;

    typedef struct packed {
        token_kind_t token_kind;
        logic [15:0] token_start;
        logic [16:0] token_length;
        logic        last_of_run;
    } cct_result_t;

    typedef struct packed {
        logic [1:0]  count;
        cct_result_t res0;
        cct_result_t res1;
    } cct_step_out_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_E      = 8'h65;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

// ===== design/character_class_tokenizer.sv =====
// Top level of the character class tokenizer: input register, scan step and
// result queue. Depends on cct_pkg, cct_step and cct_res_fifo.
//
// Usage: one text byte per transfer on s_item (character, end_of_text), with
// end_of_text set on the final byte of each text. Each token comes out as one
// transfer on m_result with its kind, start offset and length; last_of_run
// marks the final result caused by a given input byte, and a byte may cause
// none, one or two results. Both channels use valid/ready.
// A result caused by a byte passes the input register and then the result
// queue before it is offered on m_result.
// Throughput: one byte per cycle. The byte in the input register is scanned
// once the four-entry result queue has space for two results, so a stalled
// receiver fills the queue and then holds s_ready low.
// Reset (aresetn low, synchronous) empties the input register and the queue
// and puts the scanner between tokens at offset zero. After the byte flagged
// end_of_text the scanner returns to that state, ready for a new text.
module character_class_tokenizer
    import cct_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  cct_item_t   s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output cct_result_t m_result
);

    logic          in_valid_reg, in_valid_next;
    cct_item_t     in_reg;
    logic          room;
    logic          fire;
    cct_step_out_t step_out;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    cct_step #(
        .MAX_TEXT(MAX_TEXT)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_reg),
        .step_out(step_out)
    );

    cct_res_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_en (fire),
        .push    (step_out),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_result(m_result)
    );

`ifndef NO_ASSERTIONS
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_reg))
        else $error("input register lost a byte that was not scanned");
`endif

endmodule

// ===== design/cct_step.sv =====
// Tokenizer scan state and the per-character step logic that yields up to two
// results for each transfer. Depends on cct_pkg.
module cct_step
    import cct_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  cct_item_t     item,
    output cct_step_out_t step_out
);

    localparam int POS_W = $clog2(MAX_TEXT + 1);
    localparam int EXT_W = (POS_W > 17) ? POS_W : 17;
    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_TEXT);
    localparam logic [POS_W-1:0] ORIGIN_MAX = POS_W'(MAX_TEXT - 1);

    typedef struct packed {
        logic             valid;
        token_kind_t      kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
    } emit_t;

    scan_mode_t       mode_reg, mode_next;
    logic [POS_W-1:0] origin_reg, origin_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             quote_reg, quote_next;
    logic             esc_reg, esc_next;
    logic             halted_reg, halted_next;

    logic [7:0]       c;
    logic             last;
    logic [POS_W-1:0] incl;
    logic [POS_W-1:0] o_p;
    logic [POS_W-1:0] str_start;

    scan_mode_t       st_mode;
    logic             st_halt;
    logic             st_quote_we;
    logic             st_quote;
    emit_t            st_emit;

    emit_t            e1, e2, e3, first, second;
    logic             do_start;
    logic             cont;
    token_kind_t      run_kind;

    function automatic logic [POS_W-1:0] span(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic cct_result_t to_result(emit_t e, logic fin);
        cct_result_t r;
        logic [EXT_W-1:0] s_ext;
        logic [EXT_W-1:0] l_ext;
        s_ext = EXT_W'(e.start);
        l_ext = EXT_W'(e.len);
        r.token_kind   = e.kind;
        r.token_start  = s_ext[15:0];
        r.token_length = l_ext[16:0];
        r.last_of_run  = fin;
        return r;
    endfunction

    assign c    = item.character;
    assign last = item.end_of_text;
    assign incl = (pos_reg == POS_MAX) ? POS_MAX : (pos_reg + 1'b1);
    assign o_p  = (pos_reg > ORIGIN_MAX) ? ORIGIN_MAX : pos_reg;
    assign str_start = ((origin_reg + 1'b1) > ORIGIN_MAX) ? ORIGIN_MAX : (origin_reg + 1'b1);

    // Classification of a character that opens a new token.
    always_comb begin
        st_mode     = MODE_IDLE;
        st_halt     = 1'b0;
        st_quote_we = 1'b0;
        st_quote    = (c == CH_SQUOTE);
        st_emit     = '{valid: 1'b0, kind: KIND_INVALID, start: o_p, len: POS_W'(1)};
        if (c == CH_NUL) begin
            st_halt = 1'b1;
        end else if (c == CH_CR) begin
            if (last) begin
                st_emit.valid = 1'b1;
                st_emit.kind  = KIND_NEWLINE;
            end else begin
                st_mode = MODE_CR;
            end
        end else if (c == CH_LF) begin
            st_emit.valid = 1'b1;
            st_emit.kind  = KIND_NEWLINE;
        end else if ((c == CH_SPACE) || (c == CH_TAB)) begin
            st_mode = MODE_SPACE;
        end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            st_mode     = MODE_STRING;
            st_quote_we = 1'b1;
        end else if (c == CH_MINUS) begin
            if (last) begin
                st_emit.valid = 1'b1;
            end else begin
                st_mode = MODE_MINUS;
            end
        end else if (is_alpha(c) || (c == CH_UNDER)) begin
            st_mode = MODE_IDENT;
        end else if (is_digit(c)) begin
            st_mode = MODE_NUMBER;
        end else begin
            st_emit.valid = 1'b1;
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        origin_next = origin_reg;
        quote_next  = quote_reg;
        esc_next    = esc_reg;
        halted_next = halted_reg;
        pos_next    = incl;
        e1          = '{valid: 1'b0, kind: KIND_INVALID, start: origin_reg, len: POS_W'(1)};
        e2          = e1;
        e3          = e1;
        do_start    = 1'b0;
        cont        = 1'b0;
        run_kind    = KIND_SPACE;

        case (mode_reg)
            MODE_SPACE: begin
                cont     = (c == CH_SPACE) || (c == CH_TAB);
                run_kind = KIND_SPACE;
            end
            MODE_IDENT: begin
                cont     = is_alpha(c) || is_digit(c) || (c == CH_UNDER);
                run_kind = KIND_IDENT;
            end
            MODE_NUMBER: begin
                cont = is_digit(c) || (c == CH_DOT) || (c == CH_MINUS) || (c == CH_E);
                run_kind = KIND_NUMBER;
            end
            default: begin
                cont     = 1'b0;
                run_kind = KIND_SPACE;
            end
        endcase

        if (!halted_reg) begin
            case (mode_reg)
                MODE_CR: begin
                    mode_next = MODE_IDLE;
                    e1.valid  = 1'b1;
                    e1.kind   = KIND_NEWLINE;
                    if (c == CH_LF) begin
                        e1.len = POS_W'(2);
                    end else begin
                        do_start = 1'b1;
                    end
                end
                MODE_MINUS: begin
                    if (is_digit(c)) begin
                        mode_next = MODE_NUMBER;
                    end else begin
                        mode_next = MODE_IDLE;
                        e1.valid  = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                MODE_SPACE, MODE_IDENT, MODE_NUMBER: begin
                    if (!cont) begin
                        mode_next = MODE_IDLE;
                        e1.valid  = 1'b1;
                        e1.kind   = run_kind;
                        e1.len    = span(pos_reg, origin_reg);
                        do_start  = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                    end else if (c == (quote_reg ? CH_SQUOTE : CH_DQUOTE)) begin
                        mode_next = MODE_IDLE;
                        e1.valid  = 1'b1;
                        e1.kind   = KIND_STRING;
                        e1.start  = str_start;
                        e1.len    = span(pos_reg, str_start);
                    end else if (c == CH_BSLASH) begin
                        esc_next = 1'b1;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                    do_start  = 1'b1;
                end
            endcase

            if (do_start) begin
                mode_next   = st_mode;
                origin_next = o_p;
                halted_next = st_halt;
                e2          = st_emit;
                if (st_quote_we) begin
                    quote_next = st_quote;
                    esc_next   = 1'b0;
                end
            end

            // The end of the text closes a run that is still open.
            if (last && !halted_next) begin
                e3.start = origin_next;
                e3.len   = span(incl, origin_next);
                case (mode_next)
                    MODE_SPACE: begin
                        e3.valid = 1'b1;
                        e3.kind  = KIND_SPACE;
                    end
                    MODE_IDENT: begin
                        e3.valid = 1'b1;
                        e3.kind  = KIND_IDENT;
                    end
                    MODE_NUMBER: begin
                        e3.valid = 1'b1;
                        e3.kind  = KIND_NUMBER;
                    end
                    MODE_STRING: begin
                        e3.valid = 1'b1;
                        e3.kind  = KIND_UNTERM;
                    end
                    default: begin
                        e3.valid = 1'b0;
                    end
                endcase
            end
        end

        if (last) begin
            mode_next   = MODE_IDLE;
            origin_next = '0;
            pos_next    = '0;
            quote_next  = 1'b0;
            esc_next    = 1'b0;
            halted_next = 1'b0;
        end
    end

    // A start-token result and an end-of-text result never occur together.
    always_comb begin
        first  = e1.valid ? e1 : (e2.valid ? e2 : e3);
        second = e2.valid ? e2 : e3;
        if (!e1.valid) begin
            second.valid = 1'b0;
        end
        step_out.count = 2'(e1.valid) + 2'(e2.valid) + 2'(e3.valid);
        step_out.res0  = to_result(first, !second.valid);
        step_out.res1  = to_result(second, 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            origin_reg <= '0;
            pos_reg    <= '0;
            quote_reg  <= 1'b0;
            esc_reg    <= 1'b0;
            halted_reg <= 1'b0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            origin_reg <= origin_next;
            pos_reg    <= pos_next;
            quote_reg  <= quote_next;
            esc_reg    <= esc_next;
            halted_reg <= halted_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.end_of_text |=>
            (pos_reg == '0) && (mode_reg == MODE_IDLE) && !halted_reg)
        else $error("end of text did not return the scanner to its reset state");

    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && halted_reg |-> step_out.count == 2'd0)
        else $error("halted scanner produced a result");
`endif

endmodule

// ===== design/cct_res_fifo.sv =====
// Result queue that takes up to two results per cycle and delivers one
// transfer per cycle on the result channel while m_ready is high. Depends on cct_pkg.
module cct_res_fifo
    import cct_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_en,
    input  cct_step_out_t push,
    output logic          room,
    output logic          m_valid,
    input  logic          m_ready,
    output cct_result_t   m_result
);

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    cct_result_t      mem_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       push_n;
    logic             pop;

    assign push_n   = push_en ? push.count : 2'd0;
    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_result = mem_reg[rd_ptr_reg];
    assign room     = (count_reg <= CNT_W'(RES_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + 1'b1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_n != 2'd0 |-> count_reg <= CNT_W'(RES_DEPTH - 2))
        else $error("results pushed without room for two");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (push_n == 2'd0) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count wrong after a lone pop");
`endif

endmodule
